// ===== sv/assert_macros.svh =====
// Assertion macros used by the back part of the neighbor cell search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/shnc_pkg.sv =====
// Package with types and constants of the spatial hash neighbor cell search.
`timescale 1ns / 1ps
`default_nettype none

package shnc_pkg;

    // Number of neighbor cells visited around a particle.
    localparam int NEIGHBOR_CELLS = 27;
    localparam int SEEN_IW = $clog2(NEIGHBOR_CELLS);

    // Hash primes, one per axis.
    localparam logic [31:0] HASH_PX = 32'd73856093;
    localparam logic [31:0] HASH_PY = 32'd19349663;
    localparam logic [31:0] HASH_PZ = 32'd83492791;

    // Remainder unit: bits retired per cycle and steps for a 32-bit hash.
    localparam int MOD_BITS = 4;
    localparam int MOD_CYCLES = 32 / MOD_BITS;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_INV_CELL_SIZE = 1'b0,
        REG_TABLE_CELLS   = 1'b1
    } reg_index_t;

    // Item passed from front to back.
    typedef struct packed {
        logic signed [31:0] ci;
        logic signed [31:0] cj;
        logic signed [31:0] ck;
        logic               unchanged;
    } cell_item_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_HASH,
        B_MOD,
        B_DEDUP,
        B_EMIT,
        B_UNCH
    } back_state_t;

    // Neighbor offset code 0, 1, 2 stands for -1, 0, +1.
    function automatic logic [31:0] offset_of(input logic [1:0] code);
        logic [31:0] off;
        off = 32'd0;
        unique case (code)
            2'd0:    off = 32'hFFFF_FFFF;
            2'd1:    off = 32'd0;
            2'd2:    off = 32'd1;
            default: off = 32'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== sv/shnc_queue.sv =====
// Short queue that decouples the cell computation from the key enumeration.
`timescale 1ns / 1ps
`default_nettype none

module shnc_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  shnc_pkg::cell_item_t push_data,
    input  wire                  pop,
    output shnc_pkg::cell_item_t pop_data,
    output shnc_pkg::queue_status_t status
);

    localparam int PW = $clog2(shnc_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(shnc_pkg::QUEUE_DEPTH + 1);

    shnc_pkg::cell_item_t mem_reg [shnc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(shnc_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(shnc_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(shnc_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ===== sv/shnc_front.sv =====
// Front part: accepts a particle, computes its grid cell and classifies it.
`timescale 1ns / 1ps
`default_nettype none

module shnc_front (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire signed [31:0]      pos_x,
    input  wire signed [31:0]      pos_y,
    input  wire signed [31:0]      pos_z,
    input  wire signed [31:0]      prev_i,
    input  wire signed [31:0]      prev_j,
    input  wire signed [31:0]      prev_k,
    input  wire [31:0]             inv_cell_size,
    input  shnc_pkg::queue_status_t q_status,
    output logic                   q_push,
    output shnc_pkg::cell_item_t   q_data
);

    shnc_pkg::front_state_t state_reg, state_next;
    logic [1:0]         axis_reg;
    logic signed [31:0] pos_reg  [3];
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] cell_reg [3];
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] product;
    logic               accept;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shnc_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = shnc_pkg::F_MUL;
                end
            end
            shnc_pkg::F_MUL:
            begin
                if (axis_reg == 2'd2)
                begin
                    state_next = shnc_pkg::F_PUSH;
                end
            end
            shnc_pkg::F_PUSH:
            begin
                if (!q_status.full)
                begin
                    state_next = shnc_pkg::F_IDLE;
                end
            end
            default: state_next = shnc_pkg::F_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready = 1'b0;
        q_push   = 1'b0;
        unique case (state_reg)
            shnc_pkg::F_IDLE: in_ready = 1'b1;
            shnc_pkg::F_MUL:  in_ready = 1'b0;
            shnc_pkg::F_PUSH: q_push   = !q_status.full;
            default:          in_ready = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shnc_pkg::F_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                axis_reg <= 2'd0;
            end
            else if (state_reg == shnc_pkg::F_MUL)
            begin
                axis_reg <= axis_reg + 2'd1;
            end
        end
    end

    // One shared signed-by-unsigned multiplier, one axis per cycle.
    // The cell is the floor of the Q32.32 product, i.e. its upper word.
    assign mul_a   = {pos_reg[axis_reg][31], pos_reg[axis_reg]};
    assign mul_b   = {1'b0, inv_cell_size};
    assign product = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg[0]  <= pos_x;
            pos_reg[1]  <= pos_y;
            pos_reg[2]  <= pos_z;
            prev_reg[0] <= prev_i;
            prev_reg[1] <= prev_j;
            prev_reg[2] <= prev_k;
        end
        if (state_reg == shnc_pkg::F_MUL)
        begin
            cell_reg[axis_reg] <= product[63:32];
        end
    end

    // Item for the back part, with the unchanged classification.
    assign q_data.ci        = cell_reg[0];
    assign q_data.cj        = cell_reg[1];
    assign q_data.ck        = cell_reg[2];
    assign q_data.unchanged = (cell_reg[0] == prev_reg[0]) &&
                              (cell_reg[1] == prev_reg[1]) &&
                              (cell_reg[2] == prev_reg[2]);

endmodule

`default_nettype wire

// ===== sv/shnc_back.sv =====
// Back part: hashes the 27 neighbor cells, drops repeated keys and emits results.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module shnc_back #(
    parameter int KEY_WIDTH = 20
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  shnc_pkg::queue_status_t q_status,
    input  shnc_pkg::cell_item_t    q_data,
    output logic                    q_pop,
    input  wire [20:0]              table_cells,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic signed [31:0]      cell_i,
    output logic signed [31:0]      cell_j,
    output logic signed [31:0]      cell_k,
    output logic                    unchanged,
    output logic [KEY_WIDTH-1:0]    neighbor_key,
    output logic                    last_key
);

    localparam int MW  = KEY_WIDTH + 1;
    localparam int IW  = shnc_pkg::SEEN_IW;
    localparam int SCW = $clog2(shnc_pkg::MOD_CYCLES);

    shnc_pkg::back_state_t state_reg, state_next;
    shnc_pkg::cell_item_t  item_reg;
    logic [1:0]            dx_reg, dy_reg, dz_reg;
    logic [1:0]            hstep_reg;
    logic [SCW-1:0]        mstep_reg;
    logic [31:0]           hash_reg;
    logic [MW-1:0]         rem_reg;
    logic [KEY_WIDTH-1:0]  seen_reg [shnc_pkg::NEIGHBOR_CELLS];
    logic [IW-1:0]         count_reg;
    logic [IW-1:0]         idx_reg;
    logic                  out_valid_reg;
    logic signed [31:0]    out_ci_reg, out_cj_reg, out_ck_reg;
    logic                  out_unch_reg, out_last_reg;
    logic [KEY_WIDTH-1:0]  out_key_reg;

    logic [63:0]           tc_wide;
    logic [63:0]           lim_wide;
    logic [MW-1:0]         modulus;
    logic [31:0]           operand;
    logic [31:0]           prime;
    logic [31:0]           mul_low;
    logic [MW-1:0]         rem_next;
    logic [MW:0]           rem_shift;
    logic [KEY_WIDTH-1:0]  key;
    logic                  dup;
    logic                  last_cand;
    logic                  out_free;
    logic                  load_emit;
    logic                  load_unch;
    logic                  emit_last;

    // Effective modulus, clamped to the key range.
    assign tc_wide  = 64'(table_cells);
    assign lim_wide = 64'(1) << KEY_WIDTH;
    assign modulus  = (tc_wide > lim_wide) ? MW'(lim_wide) : MW'(tc_wide);

    assign last_cand = (dx_reg == 2'd2) && (dy_reg == 2'd2) && (dz_reg == 2'd2);
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_last = (idx_reg == count_reg - IW'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shnc_pkg::B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = q_data.unchanged ? shnc_pkg::B_UNCH : shnc_pkg::B_HASH;
                end
            end
            shnc_pkg::B_HASH:
            begin
                if (hstep_reg == 2'd2)
                begin
                    state_next = shnc_pkg::B_MOD;
                end
            end
            shnc_pkg::B_MOD:
            begin
                if (mstep_reg == SCW'(shnc_pkg::MOD_CYCLES - 1))
                begin
                    state_next = shnc_pkg::B_DEDUP;
                end
            end
            shnc_pkg::B_DEDUP:
            begin
                state_next = last_cand ? shnc_pkg::B_EMIT : shnc_pkg::B_HASH;
            end
            shnc_pkg::B_EMIT:
            begin
                if (out_free && emit_last)
                begin
                    state_next = shnc_pkg::B_IDLE;
                end
            end
            shnc_pkg::B_UNCH:
            begin
                if (out_free)
                begin
                    state_next = shnc_pkg::B_IDLE;
                end
            end
            default: state_next = shnc_pkg::B_IDLE;
        endcase
    end

    // Control outputs of each state.
    always_comb
    begin
        q_pop     = 1'b0;
        load_emit = 1'b0;
        load_unch = 1'b0;
        unique case (state_reg)
            shnc_pkg::B_IDLE:  q_pop     = !q_status.empty;
            shnc_pkg::B_EMIT:  load_emit = out_free;
            shnc_pkg::B_UNCH:  load_unch = out_free;
            shnc_pkg::B_HASH,
            shnc_pkg::B_MOD,
            shnc_pkg::B_DEDUP: q_pop     = 1'b0;
            default:           q_pop     = 1'b0;
        endcase
    end

    // Hash: one multiplier, one axis per cycle, products folded by XOR.
    always_comb
    begin
        operand = 32'(item_reg.ci) + shnc_pkg::offset_of(dx_reg);
        prime   = shnc_pkg::HASH_PX;
        unique case (hstep_reg)
            2'd0:
            begin
                operand = 32'(item_reg.ci) + shnc_pkg::offset_of(dx_reg);
                prime   = shnc_pkg::HASH_PX;
            end
            2'd1:
            begin
                operand = 32'(item_reg.cj) + shnc_pkg::offset_of(dy_reg);
                prime   = shnc_pkg::HASH_PY;
            end
            2'd2:
            begin
                operand = 32'(item_reg.ck) + shnc_pkg::offset_of(dz_reg);
                prime   = shnc_pkg::HASH_PZ;
            end
            default:
            begin
                operand = 32'd0;
                prime   = 32'd0;
            end
        endcase
        mul_low = operand * prime;
    end

    // Restoring remainder, MOD_BITS bits of the hash per cycle, MSB first.
    always_comb
    begin
        rem_next  = rem_reg;
        rem_shift = '0;
        for (int b = 0; b < shnc_pkg::MOD_BITS; b++)
        begin
            rem_shift = {rem_next, hash_reg[31 - b]};
            if (rem_shift >= {1'b0, modulus})
            begin
                rem_shift = rem_shift - {1'b0, modulus};
            end
            rem_next = rem_shift[MW-1:0];
        end
    end

    // Key and compare against the keys already kept for this item.
    assign key = (modulus == '0) ? '0 : rem_reg[KEY_WIDTH-1:0];

    always_comb
    begin
        dup = 1'b0;
        for (int n = 0; n < shnc_pkg::NEIGHBOR_CELLS; n++)
        begin
            if ((IW'(n) < count_reg) && (seen_reg[n] == key))
            begin
                dup = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shnc_pkg::B_IDLE;
            dx_reg        <= 2'd0;
            dy_reg        <= 2'd0;
            dz_reg        <= 2'd0;
            hstep_reg     <= 2'd0;
            mstep_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                dx_reg    <= 2'd0;
                dy_reg    <= 2'd0;
                dz_reg    <= 2'd0;
                hstep_reg <= 2'd0;
                count_reg <= '0;
                idx_reg   <= '0;
            end
            if (state_reg == shnc_pkg::B_HASH)
            begin
                hstep_reg <= (hstep_reg == 2'd2) ? 2'd0 : hstep_reg + 2'd1;
                mstep_reg <= '0;
            end
            if (state_reg == shnc_pkg::B_MOD)
            begin
                mstep_reg <= mstep_reg + SCW'(1);
            end
            if (state_reg == shnc_pkg::B_DEDUP)
            begin
                if (!dup)
                begin
                    count_reg <= count_reg + IW'(1);
                end
                if (dz_reg != 2'd2)
                begin
                    dz_reg <= dz_reg + 2'd1;
                end
                else
                begin
                    dz_reg <= 2'd0;
                    if (dy_reg != 2'd2)
                    begin
                        dy_reg <= dy_reg + 2'd1;
                    end
                    else
                    begin
                        dy_reg <= 2'd0;
                        dx_reg <= dx_reg + 2'd1;
                    end
                end
            end
            if (load_emit)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (load_emit || load_unch)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_data;
        end
        if (state_reg == shnc_pkg::B_HASH)
        begin
            hash_reg <= (hstep_reg == 2'd0) ? mul_low : (hash_reg ^ mul_low);
            rem_reg  <= '0;
        end
        if (state_reg == shnc_pkg::B_MOD)
        begin
            rem_reg  <= rem_next;
            hash_reg <= hash_reg << shnc_pkg::MOD_BITS;
        end
        if ((state_reg == shnc_pkg::B_DEDUP) && !dup)
        begin
            seen_reg[count_reg] <= key;
        end
        if (load_emit || load_unch)
        begin
            out_ci_reg   <= item_reg.ci;
            out_cj_reg   <= item_reg.cj;
            out_ck_reg   <= item_reg.ck;
            out_unch_reg <= load_unch;
            out_key_reg  <= load_unch ? '0 : seen_reg[idx_reg];
            out_last_reg <= load_unch || emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_i       = out_ci_reg;
    assign cell_j       = out_cj_reg;
    assign cell_k       = out_ck_reg;
    assign unchanged    = out_unch_reg;
    assign neighbor_key = out_key_reg;
    assign last_key     = out_last_reg;

    // The kept key count never passes the neighbor count.
    `ASSERT_SAME(a_count_range, clk, rst_n, 1'b1,
                 count_reg <= IW'(shnc_pkg::NEIGHBOR_CELLS))
    // Emission only reads keys that were kept for this item.
    `ASSERT_SAME(a_emit_index, clk, rst_n, state_reg == shnc_pkg::B_EMIT,
                 idx_reg < count_reg)
    // An unchanged result is always the final one of its item.
    `ASSERT_SAME(a_unch_last, clk, rst_n, out_valid_reg && out_unch_reg,
                 out_last_reg)

endmodule

`default_nettype wire

// ===== sv/spatial_hash_neighbor_cells_core.sv =====
// Top level of the spatial hash neighbor cell search.
//
// Each particle's grid cell is computed as floor(position * inv_cell_size) with one
// shared multiplier, one axis per cycle, in the front part. An item whose cell
// equals its previous cell gives one result flagged unchanged. Otherwise the back
// part visits the 27 neighbor cells, dx then dy then dz; each one passes through
// the hash multiplies, the remainder unit retiring four bits a cycle, and the
// duplicate check, and the remainder unit takes the largest share of that work.
// Every distinct key is emitted once, in first-seen order, the last one flagged
// last_key. Configuration must be written by the user only while the block is
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module spatial_hash_neighbor_cells_core #(
    parameter int KEY_WIDTH = 20
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_wr_en,
    input  wire [0:0]               cfg_index,
    input  wire [31:0]              cfg_wdata,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire signed [31:0]       pos_x,
    input  wire signed [31:0]       pos_y,
    input  wire signed [31:0]       pos_z,
    input  wire signed [31:0]       prev_i,
    input  wire signed [31:0]       prev_j,
    input  wire signed [31:0]       prev_k,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic signed [31:0]      cell_i,
    output logic signed [31:0]      cell_j,
    output logic signed [31:0]      cell_k,
    output logic                    unchanged,
    output logic [KEY_WIDTH-1:0]    neighbor_key,
    output logic                    last_key
);

    logic [31:0]             inv_cell_size_reg;
    logic [20:0]             table_cells_reg;
    logic                    q_push;
    logic                    q_pop;
    shnc_pkg::cell_item_t    q_in;
    shnc_pkg::cell_item_t    q_out;
    shnc_pkg::queue_status_t q_status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_cell_size_reg <= 32'd65536;
            table_cells_reg   <= 21'd4096;
        end
        else if (cfg_wr_en)
        begin
            unique case (shnc_pkg::reg_index_t'(cfg_index))
                shnc_pkg::REG_INV_CELL_SIZE: inv_cell_size_reg <= cfg_wdata;
                shnc_pkg::REG_TABLE_CELLS:   table_cells_reg   <= cfg_wdata[20:0];
                default:                     table_cells_reg   <= table_cells_reg;
            endcase
        end
    end

    shnc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .prev_i        (prev_i),
        .prev_j        (prev_j),
        .prev_k        (prev_k),
        .inv_cell_size (inv_cell_size_reg),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    shnc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .status    (q_status)
    );

    shnc_back #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .table_cells  (table_cells_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cell_i       (cell_i),
        .cell_j       (cell_j),
        .cell_k       (cell_k),
        .unchanged    (unchanged),
        .neighbor_key (neighbor_key),
        .last_key     (last_key)
    );

endmodule

`default_nettype wire
